// ===== src/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types and constants for the set-of-stacks block with pop-at.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    // width of the pop-at position math: (index + 1) * size
    localparam int MW          = (CNT_W > 14) ? CNT_W : 14;
    localparam int SIZE_W      = 7;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 6;
    localparam int ST_W        = 2;
    localparam int OUT_CNT_W   = 7;
    localparam int RESET_SIZE  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_TOP    = 2'd2,
        OP_POP_AT = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_STACK = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  stacks;
        logic [SIZE_W-1:0] fill;
    } t_split_res;

endpackage

// ===== src/set_of_stacks_with_pop_at.sv =====
// ----------------------------------------------------------------------------
// set_of_stacks_with_pop_at
// Compacted plate store split into fixed-size stacks; push, pop, top, pop-at.
// ----------------------------------------------------------------------------
// result: strobe o_done rises in the cycle after a word is accepted
// throughput: one word per cycle while o_busy is low; all cells of the chain shift together
// a size write re-splits the store by repeated subtraction in sos_split, with o_busy high
// reset (synchronous): counts cleared, size 4; stored values are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module set_of_stacks_with_pop_at import sos_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [OP_W-1:0]             i_op,
    input  logic signed [VAL_W-1:0]     i_value,
    input  logic [IDX_W-1:0]            i_stack_index,
    input  logic                        i_cfg_we,
    input  logic [SIZE_W-1:0]           i_cfg_data,
    output logic                        o_done,
    output logic [ST_W-1:0]             o_status,
    output logic signed [VAL_W-1:0]     o_read_value,
    output logic [OUT_CNT_W-1:0]        o_element_count,
    output logic [OUT_CNT_W-1:0]        o_stack_count
);

    // cell 0 holds the newest plate, cell held-1 the oldest
    logic signed [VAL_W-1:0] cell_q [STORE_DEPTH];
    t_cell_ctl               cell_ctl [STORE_DEPTH];

    logic [SIZE_W-1:0]       r_size;
    logic [CNT_W-1:0]        r_held;
    logic [CNT_W-1:0]        r_stacks;
    logic [SIZE_W-1:0]       r_fill;
    logic                    r_done;
    logic [ST_W-1:0]         r_status;
    logic signed [VAL_W-1:0] r_rd;

    logic [CNT_W-1:0]        n_held;
    logic [CNT_W-1:0]        n_stacks;
    logic [SIZE_W-1:0]       n_fill;
    logic [ST_W-1:0]         n_status;
    logic signed [VAL_W-1:0] n_rd;

    logic [SIZE_W-1:0]       sz;
    logic [SIZE_W-1:0]       cfg_sz;
    logic                    acc;
    logic                    empty;
    logic                    full;
    logic                    push_ok;
    logic                    remove;
    logic                    k_ok;
    logic [CNT_W-1:0]        h_m1;
    logic [MW-1:0]           pos;
    logic [CNT_W-1:0]        p_cut;
    logic [CNT_W-1:0]        cut;
    logic                    split_busy;
    t_split_res              split_res;

    assign sz     = (r_size == '0) ? SIZE_W'(1) : r_size;
    assign cfg_sz = (i_cfg_data == '0) ? SIZE_W'(1) : i_cfg_data;
    assign acc    = i_start && !o_busy;
    assign empty  = (r_held == '0);
    assign full   = (MW'(r_held) >= MW'(STORE_DEPTH));
    assign h_m1   = r_held - CNT_W'(1);
    assign k_ok   = MW'(i_stack_index) < MW'(r_stacks);
    assign pos    = MW'((MW'(i_stack_index) + MW'(1)) * MW'(sz)) - MW'(1);
    // physical cell of the removed plate, counted from the newest
    assign p_cut  = (pos < MW'(h_m1)) ? CNT_W'(MW'(h_m1) - pos) : '0;

    always_comb begin
        n_status = ST_OK;
        n_rd     = '0;
        push_ok  = 1'b0;
        remove   = 1'b0;
        cut      = '0;
        case (i_op)
            OP_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    remove = 1'b1;
                end
            end
            OP_TOP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd = cell_q[0];
                end
            end
            OP_POP_AT: begin
                if (!k_ok) begin
                    n_status = ST_NO_STACK;
                end else begin
                    remove = 1'b1;
                    cut    = p_cut;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // incremental split bookkeeping
    always_comb begin
        n_held   = r_held;
        n_stacks = r_stacks;
        n_fill   = r_fill;
        if (push_ok) begin
            n_held = r_held + CNT_W'(1);
            if (empty || r_fill == sz) begin
                n_stacks = r_stacks + CNT_W'(1);
                n_fill   = SIZE_W'(1);
            end else begin
                n_fill = r_fill + SIZE_W'(1);
            end
        end else if (remove) begin
            n_held = h_m1;
            if (h_m1 == '0) begin
                n_stacks = '0;
                n_fill   = '0;
            end else if (r_fill == SIZE_W'(1)) begin
                n_stacks = r_stacks - CNT_W'(1);
                n_fill   = sz;
            end else begin
                n_fill = r_fill - SIZE_W'(1);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            logic signed [VAL_W-1:0] up_d;
            logic signed [VAL_W-1:0] dn_d;

            if (gi == 0) begin : g_first
                assign up_d = i_value;
            end else begin : g_mid
                assign up_d = cell_q[gi-1];
            end
            if (gi == STORE_DEPTH - 1) begin : g_last
                assign dn_d = '0;
            end else begin : g_inner
                assign dn_d = cell_q[gi+1];
            end

            assign cell_ctl[gi].shift_up   = acc && push_ok;
            assign cell_ctl[gi].shift_down = acc && remove && (CNT_W'(gi) >= cut);

            sos_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[gi]),
                .i_up_data   (up_d),
                .i_down_data (dn_d),
                .o_data      (cell_q[gi])
            );
        end
    endgenerate

    sos_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_size  (cfg_sz),
        .i_held  (r_held),
        .o_busy  (split_busy),
        .o_res   (split_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(RESET_SIZE);
            r_held   <= '0;
            r_stacks <= '0;
            r_fill   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= acc;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (split_res.valid) begin
                r_stacks <= split_res.stacks;
                r_fill   <= split_res.fill;
            end else if (acc) begin
                r_held   <= n_held;
                r_stacks <= n_stacks;
                r_fill   <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    assign o_busy          = split_busy;
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_value    = r_rd;
    assign o_element_count = OUT_CNT_W'(r_held);
    assign o_stack_count   = OUT_CNT_W'(r_stacks);

endmodule

// ===== src/sos_cell.sv =====
// ----------------------------------------------------------------------------
// sos_cell
// One storage cell of the plate chain: holds, takes its lower or upper neighbor.
// ----------------------------------------------------------------------------
module sos_cell import sos_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_up_data,
    input  logic signed [VAL_W-1:0] i_down_data,
    output logic signed [VAL_W-1:0] o_data
);

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            n_data = i_up_data;
        end else if (i_ctl.shift_down) begin
            n_data = i_down_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/sos_split.sv =====
// ----------------------------------------------------------------------------
// sos_split
// Re-splits the held elements under a new size by repeated subtraction.
// ----------------------------------------------------------------------------
module sos_split import sos_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [CNT_W-1:0]  i_held,
    output logic              o_busy,
    output t_split_res        o_res
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_stk;
    logic [SIZE_W-1:0] r_size;
    logic              more;

    assign more = MW'(r_rem) > MW'(r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !more) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_held;
            r_stk  <= '0;
            r_size <= i_size;
        end else if (r_busy && more) begin
            // rem above size, so size fits the count width here
            r_rem <= r_rem - CNT_W'(r_size);
            r_stk <= r_stk + CNT_W'(1);
        end
    end

    assign o_busy       = r_busy;
    assign o_res.valid  = r_busy && !more;
    assign o_res.stacks = r_stk + CNT_W'(r_rem != '0);
    assign o_res.fill   = SIZE_W'(r_rem);

endmodule

// ===== src/sos_checker.sv =====
// ----------------------------------------------------------------------------
// sos_checker
// Port-level checks on the set-of-stacks block, bound to the top level.
// ----------------------------------------------------------------------------
module sos_checker import sos_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic [OP_W-1:0]         i_op,
    input logic signed [VAL_W-1:0] i_value,
    input logic [IDX_W-1:0]        i_stack_index,
    input logic                    i_cfg_we,
    input logic [SIZE_W-1:0]       i_cfg_data,
    input logic                    o_done,
    input logic [ST_W-1:0]         o_status,
    input logic signed [VAL_W-1:0] o_read_value,
    input logic [OUT_CNT_W-1:0]    o_element_count,
    input logic [OUT_CNT_W-1:0]    o_stack_count
);

    // each accepted word gives exactly one strobe on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy) |=> o_done)
        else $error("missing result strobe");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start) && !$past(o_busy)))
        else $error("result strobe without accepted word");

    // an empty store has no stacks
    a_empty_stacks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_element_count == '0) |-> (o_stack_count == '0))
        else $error("stacks reported on empty store");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_element_count == OUT_CNT_W'(STORE_DEPTH)))
        else $error("store full reported below depth");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_read_value != '0) |-> (o_status == ST_OK))
        else $error("read word on failed request");

endmodule

bind set_of_stacks_with_pop_at sos_checker u_sos_checker (.*);

// ===== bench/tb_set_of_stacks_with_pop_at.sv =====
// ----------------------------------------------------------------------------
// tb_set_of_stacks_with_pop_at
// Self-checking bench for the set-of-stacks block. A queue of request words
// feeds a clocked driver, and a clocked monitor predicts every accepted word
// and checks each result against the oldest outstanding prediction. The run
// covers a short directed sequence, then random phases under several stack
// sizes with fill, drain and mixed traffic.
// ----------------------------------------------------------------------------
module tb_set_of_stacks_with_pop_at;
    import sos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_op               op;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  idx;
    } t_plate_word;

    typedef struct {
        t_op                   op;
        t_status               status;
        logic [VAL_W-1:0]      read_value;
        logic [OUT_CNT_W-1:0]  element_count;
        logic [OUT_CNT_W-1:0]  stack_count;
    } t_plate_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic [OP_W-1:0]        i_op = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic [IDX_W-1:0]       i_stack_index = '0;
    logic                   i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]      i_cfg_data = '0;
    logic                   o_busy;
    logic                   o_done;
    logic [ST_W-1:0]        o_status;
    logic signed [VAL_W-1:0] o_read_value;
    logic [OUT_CNT_W-1:0]   o_element_count;
    logic [OUT_CNT_W-1:0]   o_stack_count;

    set_of_stacks_with_pop_at DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_op            (i_op),
        .i_value         (i_value),
        .i_stack_index   (i_stack_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_element_count (o_element_count),
        .o_stack_count   (o_stack_count)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [VAL_W-1:0]   mdl_plates [STORE_DEPTH];
    int                 mdl_held = 0;
    logic [SIZE_W-1:0]  plate_size = SIZE_W'(RESET_SIZE);

    // generator view of the store, used only to aim pop-at indexes
    int                 gen_held = 0;
    int                 gen_size = RESET_SIZE;

    t_plate_word        words_pending [$];
    t_plate_result      plates_due [$];
    int                 sender_idle_pct = 26;
    bit                 word_taken = 1'b0;

    int mismatches = 0;
    int words_taken = 0;
    int results_seen = 0;
    int full_seen = 0;
    int empty_seen = 0;
    int no_stack_seen = 0;
    int sizes_tried = 1;

    function automatic t_plate_result apply_request(t_op op, logic [VAL_W-1:0] val,
                                                    logic [IDX_W-1:0] k);
        t_plate_result r;
        int sz;
        int pos;
        int stacks;
        sz = (plate_size == 0) ? 1 : int'(plate_size);
        stacks = (mdl_held + sz - 1) / sz;
        r.op = op;
        r.status = ST_OK;
        r.read_value = '0;
        case (op)
            OP_PUSH: begin
                if (mdl_held >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    mdl_plates[mdl_held] = val;
                    mdl_held++;
                end
            end
            OP_POP: begin
                if (mdl_held == 0) r.status = ST_EMPTY;
                else mdl_held--;
            end
            OP_TOP: begin
                if (mdl_held == 0) r.status = ST_EMPTY;
                else r.read_value = mdl_plates[mdl_held-1];
            end
            default: begin
                if (int'(k) >= stacks) begin
                    r.status = ST_NO_STACK;
                end else begin
                    // remove the top of stack k, close the gap
                    pos = int'(k) * sz + sz - 1;
                    if (pos > mdl_held - 1) pos = mdl_held - 1;
                    for (int i = pos; i + 1 < mdl_held; i++) mdl_plates[i] = mdl_plates[i+1];
                    mdl_held--;
                end
            end
        endcase
        r.element_count = OUT_CNT_W'(mdl_held);
        r.stack_count = OUT_CNT_W'((mdl_held + sz - 1) / sz);
        return r;
    endfunction

    // driver: one word per handshake, random gaps
    always @(negedge i_clk) begin
        t_plate_word w;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !word_taken) begin
            // hold the word until the block takes it
        end else if (words_pending.size() != 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct) begin
            w = words_pending.pop_front();
            i_start <= 1'b1;
            i_op <= w.op;
            i_value <= w.value;
            i_stack_index <= w.idx;
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor: check results, predict accepted words
    always @(posedge i_clk) begin
        t_plate_result want;
        if (i_rst_n) begin
            if (o_done) begin
                results_seen++;
                if (plates_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with no word outstanding, status %0d count %0d",
                                 $realtime, o_status, o_element_count);
                    mismatches++;
                end else begin
                    want = plates_due.pop_front();
                    if (o_status !== want.status || o_read_value !== want.read_value ||
                        o_element_count !== want.element_count ||
                        o_stack_count !== want.stack_count) begin
                        if (mismatches < 10) begin
                            $display("%0t: %s mismatch: want st %0d val %h cnt %0d stk %0d",
                                     $realtime, want.op.name(), want.status, want.read_value,
                                     want.element_count, want.stack_count);
                            $display("%0t: %s got st %0d val %h cnt %0d stk %0d",
                                     $realtime, want.op.name(), o_status, o_read_value,
                                     o_element_count, o_stack_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) plate_size = i_cfg_data;
            if (i_start && !o_busy) begin
                want = apply_request(t_op'(i_op), i_value, i_stack_index);
                case (want.status)
                    ST_FULL:     full_seen++;
                    ST_EMPTY:    empty_seen++;
                    ST_NO_STACK: no_stack_seen++;
                    default: ;
                endcase
                plates_due = {plates_due, want};
                words_taken++;
                word_taken = 1'b1;
            end else begin
                word_taken = 1'b0;
            end
        end else begin
            word_taken = 1'b0;
        end
    end

    task automatic queue_word(t_op op, logic [VAL_W-1:0] val, logic [IDX_W-1:0] idx);
        t_plate_word w;
        int sz;
        sz = (gen_size == 0) ? 1 : gen_size;
        w.op = op;
        w.value = val;
        w.idx = idx;
        words_pending = {words_pending, w};
        case (op)
            OP_PUSH: if (gen_held < STORE_DEPTH) gen_held++;
            OP_POP:  if (gen_held > 0) gen_held--;
            OP_POP_AT: if (int'(idx) < (gen_held + sz - 1) / sz) gen_held--;
            default: ;
        endcase
    endtask

    task automatic queue_random_phase(int n);
        int mode;
        int left;
        int pick;
        int sz;
        int stacks;
        t_op op;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
        left = 0;
        mode = 0;
        repeat (n) begin
            // traffic comes in runs: fill, drain or mixed
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(10, 90);
            end
            left--;
            pick = $urandom_range(0, 99);
            if (mode == 0) begin
                if (pick < 88) op = OP_PUSH;
                else if (pick < 92) op = OP_POP;
                else if (pick < 95) op = OP_TOP;
                else op = OP_POP_AT;
            end else if (mode == 1) begin
                if (pick < 15) op = OP_PUSH;
                else if (pick < 50) op = OP_POP;
                else if (pick < 60) op = OP_TOP;
                else op = OP_POP_AT;
            end else begin
                if (pick < 35) op = OP_PUSH;
                else if (pick < 55) op = OP_POP;
                else if (pick < 75) op = OP_TOP;
                else op = OP_POP_AT;
            end
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    2: val = 32'h0000_0000;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end else begin
                val = $urandom;
            end
            sz = (gen_size == 0) ? 1 : gen_size;
            stacks = (gen_held + sz - 1) / sz;
            // mostly aim pop-at at a stack that exists
            if (stacks > 0 && $urandom_range(0, 99) < 80)
                idx = IDX_W'($urandom_range(0, stacks - 1));
            else idx = IDX_W'($urandom_range(0, 63));
            queue_word(op, val, idx);
        end
    endtask

    task automatic wait_idle();
        while (words_pending.size() != 0 || i_start || plates_due.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_plate_size(logic [SIZE_W-1:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        gen_size = int'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sizes_tried++;
    endtask

    initial begin
        int phase_sizes [10];
        int guard;
        phase_sizes = '{0, 1, 64, 127, 3, 2, 0, 0, 5, RESET_SIZE};
        phase_sizes[6] = $urandom_range(1, 64);
        phase_sizes[7] = $urandom_range(0, 127);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset size of four
        queue_word(OP_POP,    32'h0000_0000, 6'd0);
        queue_word(OP_TOP,    32'hFFFF_FFFF, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd63);
        queue_word(OP_PUSH,   32'h7FFF_FFFF, 6'd0);
        queue_word(OP_PUSH,   32'h8000_0000, 6'd0);
        queue_word(OP_PUSH,   32'h0000_0000, 6'd0);
        queue_word(OP_PUSH,   32'hFFFF_FFFF, 6'd63);
        queue_word(OP_PUSH,   32'h5A5A_5A5A, 6'd0);
        queue_word(OP_TOP,    32'h0000_0000, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd1);
        queue_word(OP_PUSH,   32'h1234_5678, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd0);
        queue_word(OP_TOP,    32'h0000_0000, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd1);
        queue_word(OP_POP,    32'h0000_0000, 6'd0);
        queue_word(OP_POP_AT, 32'h0000_0000, 6'd0);
        queue_word(OP_POP,    32'h0000_0000, 6'd0);
        queue_word(OP_POP,    32'h0000_0000, 6'd0);
        queue_word(OP_POP,    32'h0000_0000, 6'd0);
        queue_word(OP_TOP,    32'h0000_0000, 6'd0);

        // each size change waits for the store to go quiet first
        for (int ph = 0; ph < 10; ph++) begin
            write_plate_size(SIZE_W'(phase_sizes[ph]));
            if (ph < 4) sender_idle_pct = 26;
            else if (ph < 7) sender_idle_pct = 64;
            else sender_idle_pct = 0;
            queue_random_phase(105);
        end

        while (words_pending.size() != 0 || i_start) @(negedge i_clk);
        guard = 0;
        while (plates_due.size() != 0 && guard < 200) begin
            @(negedge i_clk);
            guard++;
        end
        if (plates_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, plates_due.size());
            mismatches += plates_due.size();
        end
        repeat (4) @(posedge i_clk);

        $display("covered %0d words and %0d results over %0d stack sizes",
                 words_taken, results_seen, sizes_tried);
        $display("store full %0d, empty %0d, no such stack %0d, mismatches %0d",
                 full_seen, empty_seen, no_stack_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", plates_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sos_pkg.sv
src/sos_cell.sv
src/sos_split.sv
src/set_of_stacks_with_pop_at.sv
src/sos_checker.sv
bench/tb_set_of_stacks_with_pop_at.sv
